// ----- hw/rtl/tms_pkg.sv -----
`timescale 1ns / 1ps

package tms_pkg;

   localparam int TOTAL_W = 26;
   localparam int VALUE_W = 16;
   localparam int COUNT_W = 11;
   localparam int STATUS_W = 2;
   localparam int COUNT_LIMIT = 2047;
   localparam int TRIM_COUNT = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd2;

   typedef struct packed {
      logic [TOTAL_W-1:0] total;
      logic [VALUE_W-1:0] min_value;
      logic [VALUE_W-1:0] max_value;
      logic [COUNT_W-1:0] count;
      logic               dropped;
   } acc_type;

   typedef struct packed {
      logic               start;
      logic [TOTAL_W-1:0] dividend;
      logic [COUNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- hw/rtl/tms_accum.sv -----
`timescale 1ns / 1ps

module tms_accum
   import tms_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [VALUE_W-1:0] sample,
   input  logic               clear,
   output acc_type            acc
);

   localparam int CAP_INT = (MAX_SAMPLES > COUNT_LIMIT) ? COUNT_LIMIT : MAX_SAMPLES;
   localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAP_INT);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [VALUE_W-1:0] min_ff, min_in;
   logic [VALUE_W-1:0] max_ff, max_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [TOTAL_W:0]   sum;

   assign sum = {1'b0, total_ff} + (TOTAL_W+1)'(sample);

   always_comb begin
      total_in = total_ff;
      min_in = min_ff;
      max_in = max_ff;
      count_in = count_ff;
      dropped_in = dropped_ff;
      if (clear) begin
         total_in = '0;
         min_in = VALUE_MAX;
         max_in = '0;
         count_in = '0;
         dropped_in = 1'b0;
      end else if (take && (sample != '0)) begin
         if (count_ff >= CAP) begin
            dropped_in = 1'b1;
         end else begin
            total_in = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            if (sample < min_ff) begin
               min_in = sample;
            end
            if (sample > max_ff) begin
               max_in = sample;
            end
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         min_ff <= VALUE_MAX;
         max_ff <= '0;
         count_ff <= '0;
         dropped_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         min_ff <= min_in;
         max_ff <= max_in;
         count_ff <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   assign acc.total = total_ff;
   assign acc.min_value = min_ff;
   assign acc.max_value = max_ff;
   assign acc.count = count_ff;
   assign acc.dropped = dropped_ff;

endmodule

// ----- hw/rtl/tms_divider.sv -----
`timescale 1ns / 1ps

module tms_divider
   import tms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int STEP_W = $clog2(TOTAL_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_W - 1);

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } state_type;

   state_type          state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [TOTAL_W-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   shifted;
   logic [COUNT_W:0]   diff;
   logic               ge;

   assign shifted = {rem_ff, quo_ff[TOTAL_W-1]};
   assign ge = shifted >= {1'b0, div_ff};
   assign diff = shifted - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      done_in = 1'b0;
      case (state_ff)
         DIV_IDLE: begin
            if (req.start) begin
               quo_in = req.dividend;
               div_in = req.divisor;
               rem_in = '0;
               step_in = LAST_STEP;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            rem_in = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
            quo_in = {quo_ff[TOTAL_W-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               done_in = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = (quo_ff[TOTAL_W-1:VALUE_W] != '0) ? VALUE_MAX
                                                            : quo_ff[VALUE_W-1:0];

endmodule

// ----- hw/rtl/trimmed_mean_statistics_core.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_sample, req_is_end
// rsp       out        rsp_valid/rsp_stall   rsp_total, rsp_smallest, rsp_largest,
//                                            rsp_sample_count, rsp_mean, rsp_trimmed_mean,
//                                            rsp_status, rsp_capacity_exceeded
//
// samples are taken back to back while req_stall is low, also while a result waits
// an end marker holds req_stall high while the statistics are computed: the mean
// (not for an empty list), then the trimmed mean when there are three or more samples,
// each through the one shared divider that retires one quotient bit per cycle and
// then flags done; after that the result register is loaded, which waits while the
// previous result is stalled
// synchronous active-high reset clears the accumulators and drops any pending result

module trimmed_mean_statistics_core
   import tms_pkg::*;
#(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [VALUE_W-1:0]  req_sample,
   input  logic                req_is_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TOTAL_W-1:0]  rsp_total,
   output logic [VALUE_W-1:0]  rsp_smallest,
   output logic [VALUE_W-1:0]  rsp_largest,
   output logic [COUNT_W-1:0]  rsp_sample_count,
   output logic [VALUE_W-1:0]  rsp_mean,
   output logic [VALUE_W-1:0]  rsp_trimmed_mean,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_capacity_exceeded
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MEAN,
      ST_TRIM,
      ST_FINISH
   } state_type;

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  mean_ff, mean_in;
   logic [VALUE_W-1:0]  trim_ff, trim_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [VALUE_W-1:0]  smallest_ff, smallest_in;
   logic [VALUE_W-1:0]  largest_ff, largest_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [VALUE_W-1:0]  out_mean_ff, out_mean_in;
   logic [VALUE_W-1:0]  out_trim_ff, out_trim_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                dropped_ff, dropped_in;

   acc_type             acc;
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic                accept;
   logic                take_sample;
   logic                clear;
   logic [VALUE_W:0]    trim_edge;
   logic                trim_ok;
   logic                empty;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign take_sample = accept && !req_is_end;
   assign trim_edge = {1'b0, acc.min_value} + {1'b0, acc.max_value};
   assign trim_ok = (acc.count > COUNT_W'(TRIM_COUNT))
                    && (acc.total >= TOTAL_W'(trim_edge));
   assign empty = (acc.count == '0);

   tms_accum #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .take  (take_sample),
      .sample(req_sample),
      .clear (clear),
      .acc   (acc)
   );

   tms_divider u_divider (
      .clock(clock),
      .reset(reset),
      .req  (div_req),
      .rsp  (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      mean_in = mean_ff;
      trim_in = trim_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      total_in = total_ff;
      smallest_in = smallest_ff;
      largest_in = largest_ff;
      count_in = count_ff;
      out_mean_in = out_mean_ff;
      out_trim_in = out_trim_ff;
      status_in = status_ff;
      dropped_in = dropped_ff;
      div_req.start = 1'b0;
      div_req.dividend = acc.total;
      div_req.divisor = acc.count;
      clear = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_is_end) begin
               mean_in = '0;
               trim_in = '0;
               if (empty) begin
                  state_in = ST_FINISH;
               end else begin
                  div_req.start = 1'b1;
                  state_in = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               mean_in = div_rsp.quotient;
               if (trim_ok) begin
                  div_req.start = 1'b1;
                  div_req.dividend = acc.total - TOTAL_W'(trim_edge);
                  div_req.divisor = acc.count - COUNT_W'(TRIM_COUNT);
                  state_in = ST_TRIM;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_TRIM: begin
            if (div_rsp.done) begin
               trim_in = div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               total_in = acc.total;
               smallest_in = empty ? '0 : acc.min_value;
               largest_in = empty ? '0 : acc.max_value;
               count_in = acc.count;
               out_mean_in = mean_ff;
               out_trim_in = trim_ff;
               dropped_in = acc.dropped;
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else if (acc.count <= COUNT_W'(TRIM_COUNT)) begin
                  status_in = STATUS_SHORT;
               end else begin
                  status_in = STATUS_OK;
               end
               clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_ff <= mean_in;
      trim_ff <= trim_in;
      total_ff <= total_in;
      smallest_ff <= smallest_in;
      largest_ff <= largest_in;
      count_ff <= count_in;
      out_mean_ff <= out_mean_in;
      out_trim_ff <= out_trim_in;
      status_ff <= status_in;
      dropped_ff <= dropped_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_total = total_ff;
   assign rsp_smallest = smallest_ff;
   assign rsp_largest = largest_ff;
   assign rsp_sample_count = count_ff;
   assign rsp_mean = out_mean_ff;
   assign rsp_trimmed_mean = out_trim_ff;
   assign rsp_status = status_ff;
   assign rsp_capacity_exceeded = dropped_ff;

endmodule

// ----- hw/rtl/tms_checker.sv -----
`timescale 1ns / 1ps

module tms_checker
   import tms_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_is_end,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [TOTAL_W-1:0]  rsp_total,
   input logic [VALUE_W-1:0]  rsp_smallest,
   input logic [VALUE_W-1:0]  rsp_largest,
   input logic [COUNT_W-1:0]  rsp_sample_count,
   input logic [VALUE_W-1:0]  rsp_mean,
   input logic [VALUE_W-1:0]  rsp_trimmed_mean,
   input logic [STATUS_W-1:0] rsp_status
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_total)
         && $stable(rsp_mean) && $stable(rsp_status))
      else $error("stalled result changed");

   // end marker transfer starts the statistics pass
   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_is_end |=> req_stall)
      else $error("input not stalled after end marker");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_sample_count == '0
         && rsp_smallest == '0 && rsp_largest == '0 && rsp_mean == '0
         && rsp_trimmed_mean == '0)
      else $error("empty list result not cleared");

   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_SHORT |-> rsp_trimmed_mean == '0
         && (rsp_sample_count == 11'd1 || rsp_sample_count == 11'd2))
      else $error("short list result inconsistent");

   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |-> rsp_sample_count > 11'd2
         && rsp_smallest <= rsp_largest && rsp_smallest != '0)
      else $error("full list result inconsistent");

endmodule

bind trimmed_mean_statistics_core tms_checker u_tms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_is_end      (req_is_end),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_total       (rsp_total),
   .rsp_smallest    (rsp_smallest),
   .rsp_largest     (rsp_largest),
   .rsp_sample_count(rsp_sample_count),
   .rsp_mean        (rsp_mean),
   .rsp_trimmed_mean(rsp_trimmed_mean),
   .rsp_status      (rsp_status)
);
